>>> sv/mmh64_pkg.sv
// package: shared types, codes and constants for the murmurhash2 64b unit
`timescale 1ns / 1ps

package mmh64_pkg;

    // mix multiplier and shift amounts
    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned SHIFT_WORD  = 24;
    localparam int unsigned SHIFT_FIN_A = 18;
    localparam int unsigned SHIFT_FIN_B = 22;
    localparam int unsigned SHIFT_FIN_C = 17;
    localparam int unsigned SHIFT_FIN_D = 19;

    // default depth of the command queue
    localparam int unsigned QUEUE_DEPTH = 2;

    // word operation codes
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_FULL = 2'd1;
    localparam logic [1:0] OP_PART = 2'd2;

    // classified command handed from front to back
    typedef struct packed {
        logic        first;
        logic        last;
        logic [1:0]  op;
        logic [31:0] word;
        logic [31:0] init;
    } cmd_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> sv/mmh64_front.sv
// front: accepts input beats and classifies them into commands
`timescale 1ns / 1ps

module mmh64_front
(
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [31:0]            key_word,
    input  logic [2:0]             byte_count,
    input  logic                   first_item,
    input  logic                   last_item,
    input  logic [31:0]            seed_value,
    input  logic [31:0]            total_length,
    input  mmh64_pkg::queue_status_t q_status,
    output logic                   push,
    output mmh64_pkg::cmd_t        push_cmd
);

    logic [31:0] byte_mask;

    // mask for a partial trailing word
    always_comb
    begin
        unique case (byte_count)
            3'd1:    byte_mask = 32'h000000ff;
            3'd2:    byte_mask = 32'h0000ffff;
            3'd3:    byte_mask = 32'h00ffffff;
            default: byte_mask = 32'hffffffff;
        endcase
    end

    always_comb
    begin
        push_cmd.first = first_item;
        push_cmd.last  = last_item;
        push_cmd.word  = key_word & byte_mask;
        push_cmd.init  = seed_value ^ total_length;
        if (byte_count >= 3'd4)
        begin
            push_cmd.op = mmh64_pkg::OP_FULL;
        end
        else if (byte_count == 3'd0)
        begin
            push_cmd.op = mmh64_pkg::OP_NONE;
        end
        else
        begin
            push_cmd.op = mmh64_pkg::OP_PART;
        end
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

endmodule

>>> sv/mmh64_queue.sv
// queue: short command fifo between front and back
`timescale 1ns / 1ps

module mmh64_queue
#(
    parameter int unsigned DEPTH = mmh64_pkg::QUEUE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  mmh64_pkg::cmd_t          push_cmd,
    input  logic                     pop,
    output mmh64_pkg::cmd_t          pop_cmd,
    output mmh64_pkg::queue_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mmh64_pkg::cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> sv/mmh64_back.sv
// back: mix sequencer around one shared constant multiplier
`timescale 1ns / 1ps

module mmh64_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mmh64_pkg::queue_status_t q_status,
    input  mmh64_pkg::cmd_t          pop_cmd,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [63:0]              hash_value
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_K1   = 4'd1;
    localparam logic [3:0] ST_K2   = 4'd2;
    localparam logic [3:0] ST_HALF = 4'd3;
    localparam logic [3:0] ST_PART = 4'd4;
    localparam logic [3:0] ST_F1   = 4'd5;
    localparam logic [3:0] ST_F2   = 4'd6;
    localparam logic [3:0] ST_F3   = 4'd7;
    localparam logic [3:0] ST_F4   = 4'd8;

    logic [3:0]      state_reg, state_next;
    logic [31:0]     half_one_reg, half_one_next;
    logic [31:0]     half_two_reg, half_two_next;
    logic            parity_reg, parity_next;
    mmh64_pkg::cmd_t cmd_reg, cmd_next;
    logic [31:0]     tmp_reg, tmp_next;
    logic [31:0]     fa_reg, fa_next;
    logic [31:0]     fb_reg, fb_next;
    logic            out_valid_reg, out_valid_next;
    logic [63:0]     hash_reg, hash_next;
    logic [31:0]     mul_a;
    logic [31:0]     product;

    // the one multiplier, low 32 bits of the product
    assign product = mul_a * mmh64_pkg::MIX_MUL;

    always_comb
    begin
        state_next     = state_reg;
        half_one_next  = half_one_reg;
        half_two_next  = half_two_reg;
        parity_next    = parity_reg;
        cmd_next       = cmd_reg;
        tmp_next       = tmp_reg;
        fa_next        = fa_reg;
        fb_next        = fb_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && out_stall;
        mul_a          = '0;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop      = 1'b1;
                    cmd_next = pop_cmd;
                    if (pop_cmd.first)
                    begin
                        half_one_next = pop_cmd.init;
                        half_two_next = '0;
                        parity_next   = 1'b0;
                    end
                    if (pop_cmd.op == mmh64_pkg::OP_FULL)
                    begin
                        state_next = ST_K1;
                    end
                    else if (pop_cmd.op == mmh64_pkg::OP_PART)
                    begin
                        state_next = ST_PART;
                    end
                    else if (pop_cmd.last)
                    begin
                        state_next = ST_F1;
                    end
                end
            end
            ST_K1:
            begin
                mul_a      = cmd_reg.word;
                tmp_next   = product;
                state_next = ST_K2;
            end
            ST_K2:
            begin
                mul_a      = tmp_reg ^ (tmp_reg >> mmh64_pkg::SHIFT_WORD);
                tmp_next   = product;
                state_next = ST_HALF;
            end
            ST_HALF:
            begin
                if (parity_reg)
                begin
                    mul_a         = half_two_reg;
                    half_two_next = product ^ tmp_reg;
                end
                else
                begin
                    mul_a         = half_one_reg;
                    half_one_next = product ^ tmp_reg;
                end
                parity_next = !parity_reg;
                state_next  = cmd_reg.last ? ST_F1 : ST_IDLE;
            end
            ST_PART:
            begin
                mul_a         = half_two_reg ^ cmd_reg.word;
                half_two_next = product;
                state_next    = cmd_reg.last ? ST_F1 : ST_IDLE;
            end
            ST_F1:
            begin
                mul_a      = half_one_reg ^ (half_two_reg >> mmh64_pkg::SHIFT_FIN_A);
                fa_next    = product;
                fb_next    = half_two_reg;
                state_next = ST_F2;
            end
            ST_F2:
            begin
                mul_a      = fb_reg ^ (fa_reg >> mmh64_pkg::SHIFT_FIN_B);
                fb_next    = product;
                state_next = ST_F3;
            end
            ST_F3:
            begin
                mul_a      = fa_reg ^ (fb_reg >> mmh64_pkg::SHIFT_FIN_C);
                fa_next    = product;
                state_next = ST_F4;
            end
            ST_F4:
            begin
                mul_a = fb_reg ^ (fa_reg >> mmh64_pkg::SHIFT_FIN_D);
                if (!out_valid_reg || !out_stall)
                begin
                    hash_next      = {fa_reg, product};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            half_one_reg  <= '0;
            half_two_reg  <= '0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            half_one_reg  <= half_one_next;
            half_two_reg  <= half_two_next;
            parity_reg    <= parity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        tmp_reg  <= tmp_next;
        fa_reg   <= fa_next;
        fb_reg   <= fb_next;
        hash_reg <= hash_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

endmodule

>>> sv/murmur_hash_64b_unit.sv
// top level: murmurhash2 64b hash unit, front, command queue and back
`timescale 1ns / 1ps

// murmurhash2 variant 64b over a key delivered as little-endian 32-bit words,
// one word per input beat. the first beat of a key (first_item) also carries
// the seed and the total byte length; the last beat (last_item) yields one
// 64-bit hash beat, first half-state in bits 63:32. a beat with byte_count 0
// adds no data, so an empty key is a single beat with first and last set.
// the front classifies each beat and drops it into a short command queue
// (QUEUE_DEPTH entries), so input beats keep being taken, until the queue is
// full, while the back works and while a finished hash waits for out_stall to
// drop. the back runs all mixing through one shared 32x32 constant multiplier,
// one multiply a cycle: a full word costs a queue pop plus three multiplies, a
// partial word a pop and one multiply, an empty beat the pop alone, and a last
// beat adds four final-mix multiplies; the last waits for the output register.

module murmur_hash_64b_unit
#(
    parameter int unsigned QUEUE_DEPTH = mmh64_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input beats
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] key_word,
    input  logic [2:0]  byte_count,
    input  logic        first_item,
    input  logic        last_item,
    input  logic [31:0] seed_value,
    input  logic [31:0] total_length,
    // hash beats
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_value
);

    mmh64_pkg::queue_status_t q_status;
    mmh64_pkg::cmd_t          push_cmd;
    mmh64_pkg::cmd_t          pop_cmd;
    logic                     push;
    logic                     pop;

    // classify beats: word kind, masked partial word, seed xor length
    mmh64_front u_front
    (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .key_word     (key_word),
        .byte_count   (byte_count),
        .first_item   (first_item),
        .last_item    (last_item),
        .seed_value   (seed_value),
        .total_length (total_length),
        .q_status     (q_status),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    // decouples acceptance from the multi-cycle mix
    mmh64_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    // half-state update and final cross mix
    mmh64_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_cmd    (pop_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

endmodule
